/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthands for clocked concurrent assertions with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/i2dasc_pkg.sv */
// ----------------------------------------------------------------------------
// i2dasc_pkg
// Types, constants and the BCD correction function for the decimal converter.
// ----------------------------------------------------------------------------
package i2dasc_pkg;

  localparam int unsigned ValueW  = 32;
  localparam int unsigned CharW   = 7;
  localparam int unsigned NDigits = 10;
  localparam int unsigned BcdW    = 4 * NDigits;

  localparam logic [CharW-1:0] CharZero  = 7'd48;
  localparam logic [CharW-1:0] CharMinus = 7'd45;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StConv = 3'b010,
    StEmit = 3'b100
  } state_e;

  // Adds three to every BCD digit that is five or more, ahead of a shift.
  function automatic logic [BcdW-1:0] dabble_adj(input logic [BcdW-1:0] b);
    logic [BcdW-1:0] r;
    r = b;
    for (int i = 0; i < NDigits; i++) begin
      if (b[4*i +: 4] >= 4'd5) begin
        r[4*i +: 4] = b[4*i +: 4] + 4'd3;
      end
    end
    return r;
  endfunction

endpackage

/* rtl/int32_to_decimal_ascii.sv */
// ----------------------------------------------------------------------------
// int32_to_decimal_ascii
// Renders a signed 32-bit integer as decimal ASCII text, one character per item.
// ----------------------------------------------------------------------------
// One number is taken at a time. After the input item is accepted, the magnitude
// is shifted bit by bit into a ten-digit BCD register (shift-and-add-3), then the
// ten digit positions are walked one per cycle, a digit being held while the output
// cannot take it: leading zeros are dropped, the sign goes out alongside, and each
// remaining digit is sent most significant first, with tlast on the final one.
// A negative number of ten digits has no leading zero to drop, so its sign goes
// out on its own before the first digit. The output register lets the next number
// enter while the last character still waits. Zero gives "0" and the most negative
// value gives "-2147483648".
module int32_to_decimal_ascii
  import i2dasc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] value
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [6:0] char_code, [7] zero fill
  output logic        m_axis_tlast_o    // last
);

  `include "assert_macros.svh"

  state_e            state_q, state_d;
  logic [ValueW-1:0] mag_q, mag_d;
  logic [BcdW-1:0]   bcd_q, bcd_d;
  logic [4:0]        bit_cnt_q, bit_cnt_d;
  logic [3:0]        dig_cnt_q, dig_cnt_d;
  logic              sign_pend_q, sign_pend_d;
  logic              started_q, started_d;
  logic              out_valid_q, out_valid_d;
  logic [CharW-1:0]  out_char_q, out_char_d;
  logic              out_last_q, out_last_d;

  logic              in_acc;
  logic              slot_free;
  logic              lead_zero;
  logic [3:0]        top_digit;
  logic [BcdW-1:0]   bcd_adj;

  assign s_axis_tready_o = (state_q == StIdle);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign slot_free       = !out_valid_q || m_axis_tready_i;
  assign top_digit       = bcd_q[BcdW-1 -: 4];
  assign lead_zero       = !started_q && (top_digit == 4'd0) && (dig_cnt_q != 4'd1);
  assign bcd_adj         = dabble_adj(bcd_q);

  always_comb begin
    state_d     = state_q;
    mag_d       = mag_q;
    bcd_d       = bcd_q;
    bit_cnt_d   = bit_cnt_q;
    dig_cnt_d   = dig_cnt_q;
    sign_pend_d = sign_pend_q;
    started_d   = started_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;

    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          mag_d       = s_axis_tdata_i[31] ? (~s_axis_tdata_i + 32'd1) : s_axis_tdata_i;
          sign_pend_d = s_axis_tdata_i[31];
          bcd_d       = '0;
          bit_cnt_d   = '0;
          state_d     = StConv;
        end
      end
      StConv: begin
        bcd_d     = {bcd_adj[BcdW-2:0], mag_q[ValueW-1]};
        mag_d     = {mag_q[ValueW-2:0], 1'b0};
        bit_cnt_d = bit_cnt_q + 5'd1;
        if (bit_cnt_q == 5'd31) begin
          dig_cnt_d = 4'(NDigits);
          started_d = 1'b0;
          state_d   = StEmit;
        end
      end
      StEmit: begin
        if (sign_pend_q && slot_free) begin
          out_valid_d = 1'b1;
          out_char_d  = CharMinus;
          out_last_d  = 1'b0;
          sign_pend_d = 1'b0;
        end
        if (lead_zero) begin
          bcd_d     = {bcd_q[BcdW-5:0], 4'd0};
          dig_cnt_d = dig_cnt_q - 4'd1;
        end else if (!sign_pend_q && slot_free) begin
          out_valid_d = 1'b1;
          out_char_d  = CharZero + {3'd0, top_digit};
          out_last_d  = (dig_cnt_q == 4'd1);
          started_d   = 1'b1;
          bcd_d       = {bcd_q[BcdW-5:0], 4'd0};
          dig_cnt_d   = dig_cnt_q - 4'd1;
          if (dig_cnt_q == 4'd1) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      bit_cnt_q   <= '0;
      dig_cnt_q   <= '0;
      sign_pend_q <= 1'b0;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bit_cnt_q   <= bit_cnt_d;
      dig_cnt_q   <= dig_cnt_d;
      sign_pend_q <= sign_pend_d;
      started_q   <= started_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q      <= mag_d;
    bcd_q      <= bcd_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_char_q};
  assign m_axis_tlast_o  = out_last_q;

  `ASSERT_SAME(a_char_legal, m_axis_tvalid_o,
    (out_char_q == CharMinus) || ((out_char_q >= CharZero) && (out_char_q <= 7'd57)))
  `ASSERT_SAME(a_minus_not_last, m_axis_tvalid_o && (out_char_q == CharMinus),
    !m_axis_tlast_o)
  `ASSERT_SAME(a_emit_digits_left, state_q == StEmit, dig_cnt_q != 4'd0)
  `ASSERT_NEXT(a_conv_runs, (state_q == StConv) && (bit_cnt_q != 5'd31),
    state_q == StConv)

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking test of the signed integer to decimal ASCII converter.
// ----------------------------------------------------------------------------
// Each number sent in is rendered by a local predictor into the characters
// it should produce. Every character that leaves the block is checked against
// the oldest one that is still pending. Both stream sides idle at random,
// except during one stretch where the source and the sink run at full speed.
// ----------------------------------------------------------------------------
module testbench;
  import i2dasc_pkg::*;

  typedef struct packed {
    logic [CharW-1:0] code;
    logic             last;
  } text_char_t;

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid_i;
  logic              s_axis_tready_o;
  logic [31:0]       s_axis_tdata_i;
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i;
  logic [7:0]        m_axis_tdata_o;
  logic              m_axis_tlast_o;

  text_char_t        pending_chars[$];
  int unsigned       error_count;
  bit                no_idle;

  int32_to_decimal_ascii u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Queues the characters of the decimal text of one number.
  function automatic void predict_text(input logic [ValueW-1:0] bits);
    logic [ValueW-1:0] mag;
    logic [3:0]        digs[NDigits];
    int                ndig;
    text_char_t        ch;
    ndig = 0;
    if (bits == '0) begin
      ch.code = CharZero;
      ch.last = 1'b1;
      pending_chars.push_back(ch);
      return;
    end
    if (bits[ValueW-1]) begin
      ch.code = CharMinus;
      ch.last = 1'b0;
      pending_chars.push_back(ch);
      mag = ~bits + 1'b1;
    end else begin
      mag = bits;
    end
    while (mag != '0) begin
      digs[ndig] = 4'(mag % 10);
      mag        = mag / 10;
      ndig++;
    end
    for (int i = ndig - 1; i >= 0; i--) begin
      ch.code = CharZero + CharW'(digs[i]);
      ch.last = (i == 0);
      pending_chars.push_back(ch);
    end
  endfunction

  task automatic report_mismatch(input string what, input int expd, input int got);
    $display("%0t: mismatch in %s: expected %0d, got %0d", $time, what, expd, got);
    error_count++;
  endtask

  // Sends one number. It is entered and left at a falling edge.
  task automatic send_number(input logic [31:0] value);
    while (!no_idle && $urandom_range(0, 99) < 9) begin
      s_axis_tvalid_i = 1'b0;
      s_axis_tdata_i  = $urandom;
      @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = value;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predict_text(value);
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
  endtask

  function automatic logic [31:0] random_number();
    longint lim;
    longint mag;
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: begin
        lim = 1;
        repeat ($urandom_range(1, 10)) lim = lim * 10;
        mag = longint'($urandom) % lim;
        if (mag > 32'h7FFF_FFFF) mag = 32'h7FFF_FFFF;
        return $urandom_range(0, 1) ? -mag[31:0] : mag[31:0];
      end
      2: begin
        mag = $urandom_range(0, 99);
        return $urandom_range(0, 1) ? -mag[31:0] : mag[31:0];
      end
      default: begin
        mag = $urandom_range(0, 20);
        return $urandom_range(0, 1) ? 32'h7FFF_FFFF - mag[31:0]
                                    : 32'h8000_0000 + mag[31:0];
      end
    endcase
  endfunction

  task automatic test_extremes();
    logic [31:0] cases[$];
    cases = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
              32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1_000_000_000,
              32'd999_999_999, -32'sd999_999_999, -32'sd1_000_000_000,
              32'h5555_5555, 32'hAAAA_AAAA, 32'd1_234_567_890, -32'sd1_234_567_890,
              32'd2_000_000_000, 32'd1_999_999_999, 32'd100_000, -32'sd7};
    foreach (cases[i]) send_number(cases[i]);
  endtask

  task automatic test_full_rate();
    no_idle = 1'b1;
    repeat (60) send_number(random_number());
    no_idle = 1'b0;
  endtask

  task automatic test_random(input int unsigned count);
    repeat (count) send_number(random_number());
  endtask

  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready_i = no_idle || ($urandom_range(0, 99) >= 9);
    end
  end

  always @(posedge clk_i) begin
    text_char_t ch;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_chars.size() == 0) begin
        report_mismatch("unexpected character", -1, m_axis_tdata_o);
      end else begin
        ch = pending_chars.pop_front();
        if (m_axis_tdata_o[CharW-1:0] !== ch.code) begin
          report_mismatch("char_code", ch.code, m_axis_tdata_o[CharW-1:0]);
        end
        if (m_axis_tlast_o !== ch.last) begin
          report_mismatch("last", ch.last, m_axis_tlast_o);
        end
        if (m_axis_tdata_o[7] !== 1'b0) begin
          report_mismatch("tdata fill bit", 0, m_axis_tdata_o[7]);
        end
      end
    end
  end

  initial begin
    error_count     = 0;
    no_idle         = 1'b0;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_extremes();
    test_random(200);
    test_full_rate();
    test_random(170);
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
